>>> rtl/bia_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap id allocator package
// Sizes, command codes, state encoding and the in-byte bit search shared by
// the allocator's interfaces and modules.
// ----------------------------------------------------------------------------
package bia_pkg;

    // Bitmap capacity in bytes; each byte holds eight ids.
    localparam int MAP_BYTES = 128;
    localparam int BYTE_W    = 8;
    localparam int ID_COUNT  = MAP_BYTES * BYTE_W;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAP_BYTES + 1);
    localparam int ID_W      = 11;
    // Full id width: byte address, bit position and one more for the +1.
    localparam int FULL_W    = ADDR_W + 4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ID_W-1:0]   t_id;
    typedef logic [FULL_W-1:0] t_full;
    typedef logic [BYTE_W-1:0] t_byte;

    // Command codes.
    typedef enum logic [1:0] {
        MODE_MARK_USED = 2'd0,
        MODE_MARK_FREE = 2'd1,
        MODE_QUERY     = 2'd2,
        MODE_FIND      = 2'd3
    } t_mode;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Result of the search for a matching bit inside one byte.
    typedef struct packed {
        logic       hit;
        logic [2:0] pos;
    } t_bit_hit;

    // Finds the lowest (or, when searching downward, the highest) bit of a
    // byte whose value equals the wanted value.
    function automatic t_bit_hit find_bit(t_byte b, logic want, logic down);
        t_bit_hit r;
        r = '0;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i] == want) begin
                if (down || !r.hit) begin
                    r.hit = 1'b1;
                    r.pos = 3'(i);
                end
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/bia_if.sv
// ----------------------------------------------------------------------------
// Bitmap id allocator channels
// Valid/ready interfaces for the command beat and the result beat.
// ----------------------------------------------------------------------------

// Command channel: one beat is one command.
interface bia_cmd_if;
    logic                 valid;
    logic                 ready;
    bia_pkg::t_mode       mode;
    logic [10:0]          region_id;
    logic                 search_downward;
    logic                 search_for_used;

    modport source (
        output valid, mode, region_id, search_downward, search_for_used,
        input  ready
    );
    modport sink (
        input  valid, mode, region_id, search_downward, search_for_used,
        output ready
    );
endinterface

// Result channel: one beat per command.
interface bia_res_if;
    logic        valid;
    logic        ready;
    logic        id_in_use;
    logic        found_valid;
    logic [10:0] found_id;
    logic [10:0] highest_id;

    modport source (
        output valid, id_in_use, found_valid, found_id, highest_id,
        input  ready
    );
    modport sink (
        input  valid, id_in_use, found_valid, found_id, highest_id,
        output ready
    );
endinterface

>>> rtl/bia_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/bitmap_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap id allocator
// Keeps one bit per id in a byte-wide RAM plus the highest id in use, and
// executes mark used, mark unused, query and find commands on it.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   i_cmd     in         valid/ready    mode, region_id, search_downward,
//                                       search_for_used
//   o_res     out        valid/ready    id_in_use, found_valid, found_id,
//                                       highest_id
//
// Mark used, query and a mark unused that leaves the highest id alone go
// through the steps accept and read, modify and write, result.
// Find walks the bitmap one byte a cycle through the RAM read port. The
// rescan after unmarking the highest id also takes the modify step first.
// After reset a clearing pass writes zero to every byte with i_cmd.ready low.
// One command is in flight at a time, so a read never overlaps a write of
// the same byte. The result register lets the next command be accepted while
// a result still waits; a stalled result holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bia_cmd_if.sink          i_cmd,
    bia_res_if.source        o_res
);

    // Sequencer and command registers.
    bia_pkg::t_state r_state, n_state;
    bia_pkg::t_addr  r_addr, n_addr;
    bia_pkg::t_addr  r_chk_addr, n_chk_addr;
    bia_pkg::t_addr  r_waddr, n_waddr;
    bia_pkg::t_cnt   r_cnt, n_cnt;
    logic            r_pend, n_pend;
    bia_pkg::t_mode  r_mode, n_mode;
    bia_pkg::t_id    r_id, n_id;
    logic            r_down, n_down;
    logic            r_want, n_want;
    logic            r_rescan, n_rescan;
    bia_pkg::t_id    r_highest, n_highest;
    logic            r_res_in_use, n_res_in_use;
    logic            r_res_valid, n_res_valid;
    bia_pkg::t_id    r_res_found, n_res_found;

    // Output register.
    logic            r_out_valid;
    logic            r_out_in_use;
    logic            r_out_found_valid;
    bia_pkg::t_id    r_out_found_id;
    bia_pkg::t_id    r_out_highest;

    // RAM port signals.
    logic            w_we;
    bia_pkg::t_addr  w_waddr;
    bia_pkg::t_byte  w_wdata;
    bia_pkg::t_addr  w_raddr;
    bia_pkg::t_byte  w_rdata;

    // Decode and helpers.
    bia_pkg::t_id    w_in_idx;
    logic            w_in_ok;
    bia_pkg::t_addr  w_in_addr;
    bia_pkg::t_id    w_idx;
    logic [2:0]      w_bit;
    bia_pkg::t_byte  w_bit_mask;
    bia_pkg::t_bit_hit w_hit;
    bia_pkg::t_full  w_full;
    logic            w_out_free;
    logic            w_load;

    // Bitmap storage.
    bia_ram #(
        .WIDTH (bia_pkg::BYTE_W),
        .DEPTH (bia_pkg::MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Input id decode: range check and byte address of the id's bit.
    assign w_in_idx  = i_cmd.region_id - bia_pkg::t_id'(1);
    assign w_in_ok   = (i_cmd.region_id != '0) &&
                       (32'(i_cmd.region_id) <= bia_pkg::ID_COUNT);
    assign w_in_addr = bia_pkg::t_addr'(w_in_idx >> 3);

    // Stored command's bit position, the scan's bit search and the found id.
    assign w_idx      = r_id - bia_pkg::t_id'(1);
    assign w_bit      = w_idx[2:0];
    assign w_bit_mask = bia_pkg::t_byte'(8'd1 << w_bit);
    assign w_hit      = bia_pkg::find_bit(w_rdata, r_want, r_down);
    assign w_full     = bia_pkg::t_full'({r_chk_addr, w_hit.pos}) + bia_pkg::t_full'(1);

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_load      = (r_state == bia_pkg::ST_FINISH) && w_out_free;
    assign i_cmd.ready = (r_state == bia_pkg::ST_IDLE);

    // Next state, RAM control and result computation.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_chk_addr   = r_chk_addr;
        n_waddr      = r_waddr;
        n_cnt        = r_cnt;
        n_pend       = r_pend;
        n_mode       = r_mode;
        n_id         = r_id;
        n_down       = r_down;
        n_want       = r_want;
        n_rescan     = r_rescan;
        n_highest    = r_highest;
        n_res_in_use = r_res_in_use;
        n_res_valid  = r_res_valid;
        n_res_found  = r_res_found;
        w_we         = 1'b0;
        w_waddr      = r_waddr;
        w_wdata      = w_rdata;
        w_raddr      = r_addr;
        case (r_state)
            bia_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr;
                w_wdata = '0;
                n_addr  = r_addr + bia_pkg::t_addr'(1);
                if (r_addr == bia_pkg::t_addr'(bia_pkg::MAP_BYTES - 1)) begin
                    n_addr  = '0;
                    n_state = bia_pkg::ST_IDLE;
                end
            end
            bia_pkg::ST_IDLE: begin
                w_raddr = w_in_addr;
                if (i_cmd.valid) begin
                    n_mode       = i_cmd.mode;
                    n_id         = i_cmd.region_id;
                    n_down       = i_cmd.search_downward;
                    n_want       = i_cmd.search_for_used;
                    n_rescan     = 1'b0;
                    n_waddr      = w_in_addr;
                    n_res_in_use = 1'b0;
                    n_res_valid  = 1'b0;
                    n_res_found  = '0;
                    n_cnt        = '0;
                    n_pend       = 1'b0;
                    if (i_cmd.mode == bia_pkg::MODE_FIND) begin
                        n_addr  = i_cmd.search_downward ?
                                  bia_pkg::t_addr'(bia_pkg::MAP_BYTES - 1) : '0;
                        n_state = bia_pkg::ST_SCAN;
                    end else if (w_in_ok) begin
                        n_state = bia_pkg::ST_READ;
                    end else begin
                        n_state = bia_pkg::ST_FINISH;
                    end
                end
            end
            bia_pkg::ST_READ: begin
                // The byte holding the id's bit is on the read port now.
                n_state = bia_pkg::ST_FINISH;
                case (r_mode)
                    bia_pkg::MODE_MARK_USED: begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata | w_bit_mask;
                        if (r_id > r_highest) begin
                            n_highest = r_id;
                        end
                    end
                    bia_pkg::MODE_MARK_FREE: begin
                        w_we    = 1'b1;
                        w_wdata = w_rdata & ~w_bit_mask;
                        if (r_id == r_highest) begin
                            // Rescan downward for the new highest used id.
                            n_rescan = 1'b1;
                            n_down   = 1'b1;
                            n_want   = 1'b1;
                            n_addr   = bia_pkg::t_addr'(bia_pkg::MAP_BYTES - 1);
                            n_cnt    = '0;
                            n_pend   = 1'b0;
                            n_state  = bia_pkg::ST_SCAN;
                        end
                    end
                    bia_pkg::MODE_QUERY: begin
                        n_res_in_use = w_rdata[w_bit];
                    end
                    default: begin
                        n_state = bia_pkg::ST_FINISH;
                    end
                endcase
            end
            bia_pkg::ST_SCAN: begin
                // One read issued per cycle; the byte read last cycle is checked.
                if (r_pend && w_hit.hit) begin
                    if (r_rescan) begin
                        n_highest = bia_pkg::t_id'(w_full);
                    end else begin
                        n_res_valid = 1'b1;
                        n_res_found = bia_pkg::t_id'(w_full);
                    end
                    n_state = bia_pkg::ST_FINISH;
                end else if (r_cnt == bia_pkg::t_cnt'(bia_pkg::MAP_BYTES)) begin
                    if (r_rescan) begin
                        n_highest = '0;
                    end
                    n_state = bia_pkg::ST_FINISH;
                end else begin
                    n_pend     = 1'b1;
                    n_chk_addr = r_addr;
                    n_addr     = r_down ? (r_addr - bia_pkg::t_addr'(1)) :
                                          (r_addr + bia_pkg::t_addr'(1));
                    n_cnt      = r_cnt + bia_pkg::t_cnt'(1);
                end
            end
            bia_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = bia_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bia_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bia_pkg::ST_CLEAR;
            r_addr    <= '0;
            r_cnt     <= '0;
            r_pend    <= 1'b0;
            r_highest <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cnt     <= n_cnt;
            r_pend    <= n_pend;
            r_highest <= n_highest;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_addr   <= n_chk_addr;
        r_waddr      <= n_waddr;
        r_mode       <= n_mode;
        r_id         <= n_id;
        r_down       <= n_down;
        r_want       <= n_want;
        r_rescan     <= n_rescan;
        r_res_in_use <= n_res_in_use;
        r_res_valid  <= n_res_valid;
        r_res_found  <= n_res_found;
    end

    // Output register: loaded when the sequencer finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_in_use      <= r_res_in_use;
            r_out_found_valid <= r_res_valid;
            r_out_found_id    <= r_res_found;
            r_out_highest     <= r_highest;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.id_in_use   = r_out_in_use;
    assign o_res.found_valid = r_out_found_valid;
    assign o_res.found_id    = r_out_found_id;
    assign o_res.highest_id  = r_out_highest;

`ifndef SYNTHESIS
    // An accepted command always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != bia_pkg::ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // The highest id in use never exceeds the bitmap capacity.
    a_highest_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_highest) <= bia_pkg::ID_COUNT))
        else $error("highest id beyond bitmap capacity");

    // The scan never issues more reads than there are bytes.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bia_pkg::ST_SCAN) |->
        (32'(r_cnt) <= bia_pkg::MAP_BYTES))
        else $error("scan ran past the bitmap");

    // A new result beat appears only right after the finishing step.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid)) |-> ($past(r_state) == bia_pkg::ST_FINISH))
        else $error("result loaded outside the finishing step");
`endif

endmodule
